FILE: rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int DEF_ROWS = 25;
    localparam int DEF_COLS = 80;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;
    localparam int CELL_W = 16;
    localparam int IDX_W  = 2;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    localparam logic [IDX_W-1:0] REG_FG = 2'd0;
    localparam logic [IDX_W-1:0] REG_BG = 2'd1;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [CLR_W-1:0] FG_RESET = 4'd7;
    localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

    localparam logic [CELL_W-1:0] RESET_CELL = {BG_RESET, FG_RESET, CH_SPACE};

endpackage

FILE: rtl/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/text_console_writer_core.sv
// Text console writer core.
// Commands arrive on the input channel (i_valid / o_stall); each command yields
// exactly one result on the output channel (o_valid / i_stall) holding the read
// cell (zero unless an in-range read), the new cursor and the ignored flag.
// Colors are set through the configuration channel (i_cfg_valid / o_cfg_ready,
// index 0 foreground, 1 background); writes are always taken.
// Commands are handled one at a time. Put character and in-range read pass
// through capture, cursor and row product, address add, memory access and
// result load. Set cursor and out-of-range read skip the address add and
// memory access. A put that moves past the last row also blanks the new bottom
// row; clear blanks the whole screen. The single-port screen RAM is swept one
// cell per cycle. Scroll rotates a row base pointer instead of moving cells.
// After reset all ROWS*COLS cells (2000 by default) of the RAM are swept to
// grey-on-black spaces, with o_stall high. A finished result is held in the
// output register while i_stall is high; the next command is accepted during
// that time, but its result waits until the register frees up.
module text_console_writer_core #(
    parameter int ROWS = tcw_pkg::DEF_ROWS,
    parameter int COLS = tcw_pkg::DEF_COLS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]   i_target_row,
    input  logic [tcw_pkg::COL_W-1:0]   i_target_col,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tcw_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]  o_cell_attr,
    output logic [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]   o_cursor_col,
    output logic                        o_ignored,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tcw_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [tcw_pkg::CLR_W-1:0]   i_cfg_data
);

    import tcw_pkg::*;

    localparam int NCELL = ROWS * COLS;
    localparam int AW    = $clog2(NCELL);
    localparam logic [AW-1:0] COLS_A   = AW'(COLS);
    localparam logic [AW:0]   NCELL_X  = (AW + 1)'(NCELL);
    localparam logic [AW-1:0] LAST_A   = AW'(NCELL - 1);
    localparam logic [AW-1:0] COLS_M1  = AW'(COLS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ROW,
        S_ADDR,
        S_ACC,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [CHAR_W-1:0]  r_ch, n_ch;
    logic [ROW_W-1:0]   r_tr, n_tr;
    logic [COL_W-1:0]   r_tc, n_tc;
    logic [ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [COL_W-1:0]   r_cur_col, n_cur_col;
    logic [CLR_W-1:0]   r_fg, n_fg;
    logic [CLR_W-1:0]   r_bg, n_bg;
    logic [AW-1:0]      r_base, n_base;
    logic [AW-1:0]      r_prod, n_prod;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic               r_wr, n_wr;
    logic [CELL_W-1:0]  r_wdata, n_wdata;
    logic               r_scroll, n_scroll;
    logic               r_inrange, n_inrange;
    logic               r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]  r_o_char, n_o_char;
    logic [CHAR_W-1:0]  r_o_attr, n_o_attr;
    logic [ROW_W-1:0]   r_o_row, n_o_row;
    logic [COL_W-1:0]   r_o_col, n_o_col;
    logic               r_o_ign, n_o_ign;

    logic               mem_wr, mem_rd;
    logic [CELL_W-1:0]  mem_rdata;
    logic [CHAR_W-1:0]  attr;
    logic [ROW_W-1:0]   row_sel;
    logic               adv;
    logic [AW:0]        sum_row;
    logic [AW:0]        sum_base;
    logic [AW-1:0]      wrapped;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELL)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_rd_en   (mem_rd),
        .i_addr    (r_addr),
        .i_wr_data (r_wdata),
        .o_rd_data (mem_rdata)
    );

    assign attr    = {r_bg, r_fg};
    assign row_sel = (r_cmd == CMD_READ) ? r_tr : r_cur_row;
    assign sum_row = {1'b0, r_prod} + {1'b0, r_base};
    assign wrapped = (sum_row >= NCELL_X) ? AW'(sum_row - NCELL_X) : AW'(sum_row);
    assign sum_base = {1'b0, r_base} + {1'b0, COLS_A};

    assign mem_wr = (r_state == S_INIT) || (r_state == S_SWEEP)
                    || ((r_state == S_ACC) && r_wr && (r_cmd == CMD_PUT));
    assign mem_rd = (r_state == S_ACC) && (r_cmd == CMD_READ);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_ch      = r_ch;
        n_tr      = r_tr;
        n_tc      = r_tc;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_fg      = r_fg;
        n_bg      = r_bg;
        n_base    = r_base;
        n_prod    = r_prod;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_wr      = r_wr;
        n_wdata   = r_wdata;
        n_scroll  = r_scroll;
        n_inrange = r_inrange;
        n_ovalid  = r_ovalid;
        n_o_char  = r_o_char;
        n_o_attr  = r_o_attr;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_ign   = r_o_ign;
        adv       = 1'b0;

        if (i_cfg_valid) begin
            if (i_cfg_index == REG_FG) begin
                n_fg = i_cfg_data;
            end else if (i_cfg_index == REG_BG) begin
                n_bg = i_cfg_data;
            end
        end

        // drop the result once the receiver takes it
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_INIT, S_SWEEP: begin
                if (r_cnt == '0) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end else begin
                    n_addr = r_addr + AW'(1);
                    n_cnt  = r_cnt - AW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_ch    = i_char_code;
                    n_tr    = i_target_row;
                    n_tc    = i_target_col;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_inrange = ({1'b0, r_tr} < (ROW_W + 1)'(ROWS))
                            && ({1'b0, r_tc} < (COL_W + 1)'(COLS));
                n_prod    = AW'(AW'(row_sel) * COLS_A);
                n_wr      = 1'b0;
                n_scroll  = 1'b0;
                case (r_cmd)
                    CMD_PUT: begin
                        n_tc    = r_cur_col;
                        n_state = S_ADDR;
                        if (r_ch == CH_NEWLINE) begin
                            n_cur_col = '0;
                            adv       = 1'b1;
                        end else if (r_ch == CH_RETURN) begin
                            n_cur_col = '0;
                        end else if (r_ch == CH_BACKSPACE) begin
                            if (r_cur_col != '0) begin
                                n_cur_col = r_cur_col - COL_W'(1);
                                n_tc      = r_cur_col - COL_W'(1);
                                n_wr      = 1'b1;
                                n_wdata   = {attr, CH_SPACE};
                            end
                        end else begin
                            n_wr    = 1'b1;
                            n_wdata = {attr, r_ch};
                            if (r_cur_col == LAST_COL) begin
                                n_cur_col = '0;
                                adv       = 1'b1;
                            end else begin
                                n_cur_col = r_cur_col + COL_W'(1);
                            end
                        end
                        if (adv) begin
                            if (r_cur_row == LAST_ROW) begin
                                n_scroll = 1'b1;
                            end else begin
                                n_cur_row = r_cur_row + ROW_W'(1);
                            end
                        end
                    end
                    CMD_SET: begin
                        if (n_inrange) begin
                            n_cur_row = r_tr;
                            n_cur_col = r_tc;
                        end
                        n_state = S_DONE;
                    end
                    CMD_CLEAR: begin
                        n_cur_row = '0;
                        n_cur_col = '0;
                        n_base    = '0;
                        n_addr    = '0;
                        n_cnt     = LAST_A;
                        n_wdata   = {attr, CH_SPACE};
                        n_state   = S_SWEEP;
                    end
                    default: begin
                        n_state = n_inrange ? S_ADDR : S_DONE;
                    end
                endcase
            end
            S_ADDR: begin
                n_addr  = wrapped + AW'(r_tc);
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_scroll) begin
                    // old top row becomes the blank bottom row
                    n_addr  = r_base;
                    n_base  = (sum_base >= NCELL_X) ? '0 : AW'(sum_base);
                    n_cnt   = COLS_M1;
                    n_wdata = {attr, CH_SPACE};
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_o_row  = r_cur_row;
                    n_o_col  = r_cur_col;
                    n_o_ign  = ((r_cmd == CMD_SET) || (r_cmd == CMD_READ)) && !r_inrange;
                    if ((r_cmd == CMD_READ) && r_inrange) begin
                        n_o_char = mem_rdata[CHAR_W-1:0];
                        n_o_attr = mem_rdata[CELL_W-1:CHAR_W];
                    end else begin
                        n_o_char = '0;
                        n_o_attr = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_fg      <= FG_RESET;
            r_bg      <= BG_RESET;
            r_base    <= '0;
            r_addr    <= '0;
            r_cnt     <= LAST_A;
            r_wdata   <= RESET_CELL;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_fg      <= n_fg;
            r_bg      <= n_bg;
            r_base    <= n_base;
            r_addr    <= n_addr;
            r_cnt     <= n_cnt;
            r_wdata   <= n_wdata;
            r_ovalid  <= n_ovalid;
        end
        r_cmd     <= n_cmd;
        r_ch      <= n_ch;
        r_tr      <= n_tr;
        r_tc      <= n_tc;
        r_prod    <= n_prod;
        r_wr      <= n_wr;
        r_scroll  <= n_scroll;
        r_inrange <= n_inrange;
        r_o_char  <= n_o_char;
        r_o_attr  <= n_o_attr;
        r_o_row   <= n_o_row;
        r_o_col   <= n_o_col;
        r_o_ign   <= n_o_ign;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_cell_char  = r_o_char;
    assign o_cell_attr  = r_o_attr;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_ignored    = r_o_ign;
    assign o_cfg_ready  = 1'b1;

endmodule

FILE: rtl/tcw_checker.sv
module tcw_checker #(
    parameter int ROWS = tcw_pkg::DEF_ROWS,
    parameter int COLS = tcw_pkg::DEF_COLS
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [tcw_pkg::CHAR_W-1:0] o_cell_char,
    input logic [tcw_pkg::CHAR_W-1:0] o_cell_attr,
    input logic [tcw_pkg::ROW_W-1:0]  o_cursor_row,
    input logic [tcw_pkg::COL_W-1:0]  o_cursor_col,
    input logic                       o_ignored
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_char) && $stable(o_cell_attr)
            && $stable(o_cursor_row) && $stable(o_cursor_col) && $stable(o_ignored))
        else $error("result changed while stalled");

    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_cursor_row) < ROWS) && (int'(o_cursor_col) < COLS))
        else $error("cursor outside the screen");

    a_ign_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ignored |-> (o_cell_char == '0) && (o_cell_attr == '0))
        else $error("ignored command returned cell data");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second command taken while one is in flight");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("result or ready visible right after reset");

endmodule

bind text_console_writer_core tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (.*);
